FILE: hdl/mrc_pkg.sv
`timescale 1ns / 1ps

package mrc_pkg;

  localparam int MAX_DIMS   = 6;
  localparam int FLAT_BITS  = 32;
  localparam int COORD_BITS = 16;
  localparam int NDIM_BITS  = 3;
  localparam int CIDX_BITS  = 3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FLAT_ERR  = 2'd1,
    ST_COORD_ERR = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [CIDX_BITS-1:0] {
    CFG_NUM_DIMS = 3'd0,
    CFG_DIM_BASE = 3'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RECOMP,
    S_FLAT,
    S_DIV_START,
    S_DIV_WAIT,
    S_FIN
  } state_e;

  typedef struct packed {
    logic                  op;
    logic [FLAT_BITS-1:0]  flat_in;
    logic [COORD_BITS-1:0] coord_in_0;
    logic [COORD_BITS-1:0] coord_in_1;
    logic [COORD_BITS-1:0] coord_in_2;
    logic [COORD_BITS-1:0] coord_in_3;
    logic [COORD_BITS-1:0] coord_in_4;
    logic [COORD_BITS-1:0] coord_in_5;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [FLAT_BITS-1:0]  flat_out;
    logic [COORD_BITS-1:0] coord_out_0;
    logic [COORD_BITS-1:0] coord_out_1;
    logic [COORD_BITS-1:0] coord_out_2;
    logic [COORD_BITS-1:0] coord_out_3;
    logic [COORD_BITS-1:0] coord_out_4;
    logic [COORD_BITS-1:0] coord_out_5;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hdl/mrc_divider.sv
`timescale 1ns / 1ps

module mrc_divider import mrc_pkg::*; #(
  parameter int WIDTH = FLAT_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic [WIDTH-1:0] quotient_o,
  output logic [WIDTH-1:0] remainder_o,
  output div_stat_t        stat_o
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    trial  = {rem_q, quo_q[WIDTH-1]};
    diff   = trial - {1'b0, dvs_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CW'(WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[WIDTH]) begin
        rem_d = diff[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], 1'b1};
      end else begin
        rem_d = trial[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign stat_o      = '{busy: busy_q, done: done_q};

endmodule

FILE: hdl/mixed_radix_index_converter.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_ready_o | in_data_i (in_item_t)
// out     | output    | out_valid_o/out_ready_i | out_data_o (out_item_t)
// cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_wdata_i
// To-flat beats step through S_FLAT once per used dimension, then S_FIN.
// To-coordinate beats run one bit-serial division per used dimension. Each
// write to a register index up to MAX_DIMS restarts a stride pass through the
// shared multiplier; no input beat is taken during it. Reset loads all extents
// with one and a single dimension. A stalled output holds the next result back.

module mixed_radix_index_converter import mrc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CIDX_BITS-1:0]  cfg_idx_i,
  input  logic [COORD_BITS-1:0] cfg_wdata_i
);

  localparam int IDXW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CNTW = $clog2(MAX_DIMS + 1);
  localparam int PW   = FLAT_BITS + COORD_BITS;

  state_e state_q, state_d;

  logic [NDIM_BITS-1:0]  num_dims_q;
  logic [COORD_BITS-1:0] dim_q    [MAX_DIMS];
  logic [FLAT_BITS-1:0]  stride_q [MAX_DIMS];
  logic [FLAT_BITS-1:0]  total_q;
  logic                  over_q;
  logic [FLAT_BITS-1:0]  prod_q, prod_d;
  logic                  ovf_q, ovf_d;
  logic [CNTW-1:0]       cnt_q, cnt_d;
  logic [NDIM_BITS-1:0]  used;

  logic                  op_q;
  logic [FLAT_BITS-1:0]  acc_q, acc_d;
  logic [COORD_BITS-1:0] cin_q  [MAX_DIMS];
  logic [COORD_BITS-1:0] cres_q [MAX_DIMS];
  status_e               stat_q, stat_d;

  logic                  out_valid_q;
  out_item_t             out_q, out_d;

  logic [FLAT_BITS-1:0]  mul_a;
  logic [COORD_BITS-1:0] mul_b;
  logic [PW-1:0]         mul_p;
  logic [IDXW-1:0]       idx;
  logic                  cfg_hit;
  logic                  last_dim;

  logic                  div_start;
  logic [FLAT_BITS-1:0]  div_quo, div_rem;
  div_stat_t             div_stat;

  logic [COORD_BITS-1:0] cin_arr [MAX_DIMS];

  assign cin_arr[0] = in_data_i.coord_in_0;
  assign cin_arr[1] = in_data_i.coord_in_1;
  assign cin_arr[2] = in_data_i.coord_in_2;
  assign cin_arr[3] = in_data_i.coord_in_3;
  assign cin_arr[4] = in_data_i.coord_in_4;
  assign cin_arr[5] = in_data_i.coord_in_5;

  always_comb begin
    if (num_dims_q == '0) begin
      used = NDIM_BITS'(1);
    end else if (num_dims_q > NDIM_BITS'(MAX_DIMS)) begin
      used = NDIM_BITS'(MAX_DIMS);
    end else begin
      used = num_dims_q;
    end
  end

  assign idx      = cnt_q[IDXW-1:0];
  assign last_dim = (cnt_q == CNTW'(used) - CNTW'(1));
  assign cfg_hit  = cfg_we_i && (cfg_idx_i <= CIDX_BITS'(MAX_DIMS));

  // The one multiplier serves both the stride pass and the to-flat sum.
  assign mul_a = (state_q == S_RECOMP) ? prod_q : stride_q[idx];
  assign mul_b = (state_q == S_RECOMP) ? dim_q[idx] : cin_q[idx];
  assign mul_p = mul_a * mul_b;

  mrc_divider #(.WIDTH(FLAT_BITS)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (acc_q),
    .divisor_i   (stride_q[idx]),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .stat_o      (div_stat)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    prod_d    = prod_q;
    ovf_d     = ovf_q;
    acc_d     = acc_q;
    stat_d    = stat_q;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cnt_d  = '0;
          acc_d  = in_data_i.flat_in;
          stat_d = ST_OK;
          if (over_q) begin
            stat_d  = ST_OVERFLOW;
            state_d = S_FIN;
          end else if (!in_data_i.op) begin
            acc_d   = '0;
            state_d = S_FLAT;
          end else if (in_data_i.flat_in >= total_q) begin
            stat_d  = ST_FLAT_ERR;
            state_d = S_FIN;
          end else begin
            cnt_d   = CNTW'(used) - CNTW'(1);
            state_d = S_DIV_START;
          end
        end
      end
      S_RECOMP: begin
        if (cnt_q < CNTW'(used) && !ovf_q) begin
          if (mul_p[PW-1:FLAT_BITS] != '0) begin
            ovf_d = 1'b1;
          end else begin
            prod_d = mul_p[FLAT_BITS-1:0];
          end
        end
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(MAX_DIMS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_FLAT: begin
        if (cin_q[idx] >= dim_q[idx]) begin
          stat_d  = ST_COORD_ERR;
          state_d = S_FIN;
        end else begin
          acc_d = acc_q + mul_p[FLAT_BITS-1:0];
          cnt_d = cnt_q + CNTW'(1);
          if (last_dim) begin
            state_d = S_FIN;
          end
        end
      end
      S_DIV_START: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_stat.done) begin
          acc_d = div_rem;
          if (cnt_q == '0) begin
            state_d = S_FIN;
          end else begin
            cnt_d   = cnt_q - CNTW'(1);
            state_d = S_DIV_START;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // A register write to an index up to MAX_DIMS always starts a fresh stride pass.
    if (cfg_hit) begin
      state_d = S_RECOMP;
      cnt_d   = '0;
      prod_d  = FLAT_BITS'(1);
      ovf_d   = 1'b0;
    end
  end

  assign in_ready_o = (state_q == S_IDLE) && !cfg_hit;

  always_comb begin
    out_d        = '0;
    out_d.status = stat_q;
    if (stat_q == ST_OK) begin
      if (!op_q) begin
        out_d.flat_out = acc_q;
      end else begin
        out_d.coord_out_0 = cres_q[0];
        out_d.coord_out_1 = cres_q[1];
        out_d.coord_out_2 = cres_q[2];
        out_d.coord_out_3 = cres_q[3];
        out_d.coord_out_4 = cres_q[4];
        out_d.coord_out_5 = cres_q[5];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      prod_q      <= FLAT_BITS'(1);
      ovf_q       <= 1'b0;
      num_dims_q  <= NDIM_BITS'(1);
      total_q     <= FLAT_BITS'(1);
      over_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_DIMS; i++) begin
        dim_q[i]    <= COORD_BITS'(1);
        stride_q[i] <= FLAT_BITS'(1);
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      prod_q  <= prod_d;
      ovf_q   <= ovf_d;
      if (cfg_hit) begin
        if (cfg_idx_i == CFG_NUM_DIMS) begin
          num_dims_q <= cfg_wdata_i[NDIM_BITS-1:0];
        end else begin
          dim_q[IDXW'(cfg_idx_i - CFG_DIM_BASE)] <= cfg_wdata_i;
        end
      end
      if (state_q == S_RECOMP && !cfg_hit) begin
        stride_q[idx] <= ovf_q ? '0 : prod_q;
        if (cnt_q == CNTW'(MAX_DIMS - 1)) begin
          total_q <= ovf_d ? '0 : prod_d;
          over_q  <= ovf_d;
        end
      end
      if (state_q == S_FIN && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    stat_q <= stat_d;
    if (state_q == S_IDLE && in_valid_i && !cfg_hit) begin
      op_q <= in_data_i.op;
      for (int i = 0; i < MAX_DIMS; i++) begin
        cin_q[i]  <= cin_arr[i];
        cres_q[i] <= '0;
      end
    end
    if (state_q == S_DIV_WAIT && div_stat.done) begin
      cres_q[idx] <= div_quo[COORD_BITS-1:0];
    end
    if (state_q == S_FIN && (!out_valid_q || out_ready_i)) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.flat_out == '0 &&
    out_data_o.coord_out_0 == '0 && out_data_o.coord_out_5 == '0)
    else $error("error result carries nonzero fields");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> state_q == S_DIV_WAIT)
    else $error("divider busy outside its wait state");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat taken while an item is at work");

  a_ok_coord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_OK && out_data_o.flat_out != '0 |->
    out_data_o.coord_out_0 == '0)
    else $error("to-flat result carries coordinates");

endmodule
